/* rtl/rx_frame_sync_tracker_macros.svh */
// assertion macros for the frame sync tracker checker
// no dependencies; included by name where assertions are written
`ifndef RX_FRAME_SYNC_TRACKER_MACROS_SVH
`define RX_FRAME_SYNC_TRACKER_MACROS_SVH

// clocked assertion, disabled while reset is high
`define RFST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds during reset
`define RFST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* rtl/rfst_pkg.sv */
// shared types and constants of the frame sync tracker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rfst_pkg;

   // field widths
   localparam int CMD_W    = 3;
   localparam int MODE_W   = 3;
   localparam int WORD_W   = 32;
   localparam int TICK_W   = 64;
   localparam int CFG_W    = 16;
   localparam int LIMIT_W  = 48;
   localparam int CSR_IDX_W = 2;

   // request commands
   localparam logic [CMD_W-1:0] CMD_ARM      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CAPTURE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FRAME    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GAP      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_OVERFLOW = 3'd4;
   localparam logic [CMD_W-1:0] CMD_POLL     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_STOP     = 3'd6;

   // sync modes as reported on sync_state
   localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ARMED    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOCKED   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEGRADED = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd5;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_LARGE_GAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMER_HZ  = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0]  LARGE_GAP_RST = 16'd8;
   localparam logic [CFG_W-1:0]  TIMEOUT_RST   = 16'd1000;
   localparam logic [WORD_W-1:0] TIMER_HZ_RST  = 32'd1000000;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // latch the accepted request
      logic sub;      // elapsed ticks and tick limit
      logic mul_a;    // elapsed * 1024 - elapsed * 16
      logic mul_b;    // minus elapsed * 8
      logic cmp;      // timeout decision
      logic commit;   // update state and load the response register
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_is_poll;  // incoming request is a poll
      logic rsp_free;     // response register can take a new result
   } dp_sts_type;

endpackage

/* rtl/rx_frame_sync_tracker.sv */
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  command, epoch, tick, index, flags, lost
// rsp      out        rsp_valid / rsp_stall  frame result and full tracker status
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// a poll request goes from accept via sub, mul_a, mul_b and cmp to commit (64-bit
// subtract with the 16x32 limit product, two shift-subtract steps for x1000,
// compare, commit); all other commands go from accept to commit. The result shows the
// cycle after commit. A new request is taken while a result waits; its commit waits
// for the slot. Reset is synchronous; no clearing pass. csr writes are always taken.
//
// top level of the frame sync tracker; uses rfst_pkg, rfst_ctrl, rfst_dpath
`timescale 1ns / 1ps

module rx_frame_sync_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rfst_pkg::CMD_W-1:0]      req_command,
   input  logic [rfst_pkg::WORD_W-1:0]     req_epoch,
   input  logic [rfst_pkg::TICK_W-1:0]     req_time_tick,
   input  logic [rfst_pkg::WORD_W-1:0]     req_sample_index,
   input  logic                            req_batch_start,
   input  logic [rfst_pkg::WORD_W-1:0]     req_lost_count,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rfst_pkg::WORD_W-1:0]     rsp_frame_index_out,
   output logic                            rsp_frame_synced,
   output logic                            rsp_frame_degraded,
   output logic [rfst_pkg::MODE_W-1:0]     rsp_sync_state,
   output logic                            rsp_locked_flag,
   output logic [rfst_pkg::WORD_W-1:0]     rsp_current_epoch,
   output logic [rfst_pkg::TICK_W-1:0]     rsp_captured_tick,
   output logic [rfst_pkg::WORD_W-1:0]     rsp_start_index,
   output logic [rfst_pkg::WORD_W-1:0]     rsp_resync_total,
   output logic [rfst_pkg::WORD_W-1:0]     rsp_capture_total,
   output logic [rfst_pkg::WORD_W-1:0]     rsp_timeout_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rfst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfst_pkg::WORD_W-1:0]     csr_wdata
);
   import rfst_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // registers accept a write in any cycle
   assign csr_ready = 1'b1;

   // sequencing
   rfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // state, arithmetic and response register
   rfst_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_command         (req_command),
      .req_epoch           (req_epoch),
      .req_time_tick       (req_time_tick),
      .req_sample_index    (req_sample_index),
      .req_batch_start     (req_batch_start),
      .req_lost_count      (req_lost_count),
      .csr_wen             (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_index_out (rsp_frame_index_out),
      .rsp_frame_synced    (rsp_frame_synced),
      .rsp_frame_degraded  (rsp_frame_degraded),
      .rsp_sync_state      (rsp_sync_state),
      .rsp_locked_flag     (rsp_locked_flag),
      .rsp_current_epoch   (rsp_current_epoch),
      .rsp_captured_tick   (rsp_captured_tick),
      .rsp_start_index     (rsp_start_index),
      .rsp_resync_total    (rsp_resync_total),
      .rsp_capture_total   (rsp_capture_total),
      .rsp_timeout_total   (rsp_timeout_total)
   );

endmodule

/* rtl/rfst_ctrl.sv */
// sequencing controller of the frame sync tracker
// depends on rfst_pkg for the command and status structs
`timescale 1ns / 1ps

module rfst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rfst_pkg::dp_sts_type sts,
   output rfst_pkg::dp_cmd_type cmd
);
   import rfst_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SUB    = 6'b000010,
      ST_MUL_A  = 6'b000100,
      ST_MUL_B  = 6'b001000,
      ST_CMP    = 6'b010000,
      ST_COMMIT = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // only the idle state takes a request
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.req_is_poll ? ST_SUB : ST_COMMIT;
            end
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the response register has room
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/rfst_dpath.sv */
// datapath of the frame sync tracker: registers, timeout arithmetic, response
// depends on rfst_pkg for widths, codes and the command and status structs
`timescale 1ns / 1ps

module rfst_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rfst_pkg::dp_cmd_type                 cmd,
   output rfst_pkg::dp_sts_type                 sts,
   input  logic [rfst_pkg::CMD_W-1:0]           req_command,
   input  logic [rfst_pkg::WORD_W-1:0]          req_epoch,
   input  logic [rfst_pkg::TICK_W-1:0]          req_time_tick,
   input  logic [rfst_pkg::WORD_W-1:0]          req_sample_index,
   input  logic                                 req_batch_start,
   input  logic [rfst_pkg::WORD_W-1:0]          req_lost_count,
   input  logic                                 csr_wen,
   input  logic [rfst_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rfst_pkg::WORD_W-1:0]          csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rfst_pkg::WORD_W-1:0]          rsp_frame_index_out,
   output logic                                 rsp_frame_synced,
   output logic                                 rsp_frame_degraded,
   output logic [rfst_pkg::MODE_W-1:0]          rsp_sync_state,
   output logic                                 rsp_locked_flag,
   output logic [rfst_pkg::WORD_W-1:0]          rsp_current_epoch,
   output logic [rfst_pkg::TICK_W-1:0]          rsp_captured_tick,
   output logic [rfst_pkg::WORD_W-1:0]          rsp_start_index,
   output logic [rfst_pkg::WORD_W-1:0]          rsp_resync_total,
   output logic [rfst_pkg::WORD_W-1:0]          rsp_capture_total,
   output logic [rfst_pkg::WORD_W-1:0]          rsp_timeout_total
);
   import rfst_pkg::*;

   // configuration registers
   logic [CFG_W-1:0]  large_gap_ff;
   logic [CFG_W-1:0]  timeout_ms_ff;
   logic [WORD_W-1:0] timer_hz_ff;

   // latched request
   logic [CMD_W-1:0]  cmd_ff;
   logic [WORD_W-1:0] req_epoch_ff;
   logic [TICK_W-1:0] tick_ff;
   logic [WORD_W-1:0] index_ff;
   logic              bstart_ff;
   logic [WORD_W-1:0] lost_ff;

   // tracker state
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              locked_ff, locked_in;
   logic [WORD_W-1:0] epoch_ff, epoch_in;
   logic [TICK_W-1:0] cap_tick_ff, cap_tick_in;
   logic [WORD_W-1:0] start_ff, start_in;
   logic [WORD_W-1:0] resync_ff, resync_in;
   logic [WORD_W-1:0] cap_cnt_ff, cap_cnt_in;
   logic [WORD_W-1:0] tmo_cnt_ff, tmo_cnt_in;
   logic [TICK_W-1:0] armed_at_ff, armed_at_in;
   logic              armed_before_ff, armed_before_in;

   // timeout arithmetic
   logic [TICK_W-1:0]  elapsed_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [TICK_W-1:0]  prod_ff;
   logic               tout_ff;

   // frame outcome
   logic [WORD_W-1:0] fidx;
   logic              fsync;
   logic              fdeg;

   // response register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_fidx_ff;
   logic              rsp_fsync_ff;
   logic              rsp_fdeg_ff;
   logic [MODE_W-1:0] rsp_mode_ff;
   logic              rsp_locked_ff;
   logic [WORD_W-1:0] rsp_epoch_ff;
   logic [TICK_W-1:0] rsp_cap_tick_ff;
   logic [WORD_W-1:0] rsp_start_ff;
   logic [WORD_W-1:0] rsp_resync_ff;
   logic [WORD_W-1:0] rsp_cap_cnt_ff;
   logic [WORD_W-1:0] rsp_tmo_cnt_ff;

   // status to the controller
   assign sts.req_is_poll = (req_command == CMD_POLL);
   assign sts.rsp_free    = !rsp_valid_ff || !rsp_stall;

   // csr writes, out-of-range index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         large_gap_ff  <= LARGE_GAP_RST;
         timeout_ms_ff <= TIMEOUT_RST;
         timer_hz_ff   <= TIMER_HZ_RST;
      end else if (csr_wen) begin
         case (csr_index)
            REG_LARGE_GAP: large_gap_ff  <= csr_wdata[CFG_W-1:0];
            REG_TIMEOUT:   timeout_ms_ff <= csr_wdata[CFG_W-1:0];
            REG_TIMER_HZ:  timer_hz_ff   <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff       <= req_command;
         req_epoch_ff <= req_epoch;
         tick_ff      <= req_time_tick;
         index_ff     <= req_sample_index;
         bstart_ff    <= req_batch_start;
         lost_ff      <= req_lost_count;
      end
   end

   // timeout test over four steps: elapsed * 1000 >= timeout_ms * timer_hz,
   // with 1000 = 1024 - 16 - 8; the product is exact below 2^54 elapsed ticks
   always_ff @(posedge clock) begin
      if (cmd.sub) begin
         elapsed_ff <= tick_ff - armed_at_ff;
         limit_ff   <= LIMIT_W'(timeout_ms_ff) * LIMIT_W'(timer_hz_ff);
      end
      if (cmd.mul_a) begin
         prod_ff <= {elapsed_ff[TICK_W-11:0], 10'd0} - {elapsed_ff[TICK_W-5:0], 4'd0};
      end
      if (cmd.mul_b) begin
         prod_ff <= prod_ff - {elapsed_ff[TICK_W-4:0], 3'd0};
      end
      if (cmd.cmp) begin
         tout_ff <= (timer_hz_ff == '0) || (|elapsed_ff[TICK_W-1:54])
                    || (prod_ff >= {16'd0, limit_ff});
      end
   end

   // command decode and next tracker state
   always_comb begin
      mode_in         = mode_ff;
      locked_in       = locked_ff;
      epoch_in        = epoch_ff;
      cap_tick_in     = cap_tick_ff;
      start_in        = start_ff;
      resync_in       = resync_ff;
      cap_cnt_in      = cap_cnt_ff;
      tmo_cnt_in      = tmo_cnt_ff;
      armed_at_in     = armed_at_ff;
      armed_before_in = armed_before_ff;
      fidx            = '0;
      fsync           = 1'b0;
      fdeg            = 1'b0;
      case (cmd_ff)
         CMD_ARM: begin
            if (armed_before_ff) begin
               resync_in = resync_ff + 32'd1;
            end
            armed_before_in = 1'b1;
            mode_in         = MODE_ARMED;
            epoch_in        = req_epoch_ff;
            cap_tick_in     = '0;
            start_in        = '0;
            locked_in       = 1'b0;
            armed_at_in     = tick_ff;
         end
         CMD_CAPTURE: begin
            if (mode_ff == MODE_ARMED) begin
               cap_tick_in = tick_ff;
               cap_cnt_in  = cap_cnt_ff + 32'd1;
               mode_in     = MODE_WAIT;
            end
         end
         CMD_FRAME: begin
            fidx = index_ff;
            if (mode_ff == MODE_WAIT && bstart_ff) begin
               // batch start: lock and zero the index
               start_in  = index_ff;
               fidx      = '0;
               fsync     = 1'b1;
               locked_in = 1'b1;
               mode_in   = MODE_LOCKED;
            end else if (mode_ff == MODE_LOCKED) begin
               if (index_ff >= start_ff) begin
                  fidx  = index_ff - start_ff;
                  fsync = 1'b1;
               end else begin
                  // index before the batch start
                  mode_in   = MODE_ERROR;
                  locked_in = 1'b0;
               end
            end else if (mode_ff == MODE_DEGRADED) begin
               fdeg = 1'b1;
            end
         end
         CMD_GAP: begin
            if (lost_ff >= {16'd0, large_gap_ff}) begin
               mode_in   = MODE_DEGRADED;
               locked_in = 1'b0;
            end
         end
         CMD_OVERFLOW: begin
            mode_in   = MODE_DEGRADED;
            locked_in = 1'b0;
         end
         CMD_POLL: begin
            if ((mode_ff inside {MODE_ARMED, MODE_WAIT}) && tout_ff) begin
               tmo_cnt_in = tmo_cnt_ff + 32'd1;
               mode_in    = MODE_DEGRADED;
               locked_in  = 1'b0;
            end
         end
         CMD_STOP: begin
            mode_in   = MODE_IDLE;
            locked_in = 1'b0;
         end
         default: ;
      endcase
   end

   // tracker state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         locked_ff       <= 1'b0;
         epoch_ff        <= '0;
         cap_tick_ff     <= '0;
         start_ff        <= '0;
         resync_ff       <= '0;
         cap_cnt_ff      <= '0;
         tmo_cnt_ff      <= '0;
         armed_at_ff     <= '0;
         armed_before_ff <= 1'b0;
      end else if (cmd.commit) begin
         mode_ff         <= mode_in;
         locked_ff       <= locked_in;
         epoch_ff        <= epoch_in;
         cap_tick_ff     <= cap_tick_in;
         start_ff        <= start_in;
         resync_ff       <= resync_in;
         cap_cnt_ff      <= cap_cnt_in;
         tmo_cnt_ff      <= tmo_cnt_in;
         armed_at_ff     <= armed_at_in;
         armed_before_ff <= armed_before_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_fidx_ff     <= fidx;
         rsp_fsync_ff    <= fsync;
         rsp_fdeg_ff     <= fdeg;
         rsp_mode_ff     <= mode_in;
         rsp_locked_ff   <= locked_in;
         rsp_epoch_ff    <= epoch_in;
         rsp_cap_tick_ff <= cap_tick_in;
         rsp_start_ff    <= start_in;
         rsp_resync_ff   <= resync_in;
         rsp_cap_cnt_ff  <= cap_cnt_in;
         rsp_tmo_cnt_ff  <= tmo_cnt_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_index_out = rsp_fidx_ff;
   assign rsp_frame_synced    = rsp_fsync_ff;
   assign rsp_frame_degraded  = rsp_fdeg_ff;
   assign rsp_sync_state      = rsp_mode_ff;
   assign rsp_locked_flag     = rsp_locked_ff;
   assign rsp_current_epoch   = rsp_epoch_ff;
   assign rsp_captured_tick   = rsp_cap_tick_ff;
   assign rsp_start_index     = rsp_start_ff;
   assign rsp_resync_total    = rsp_resync_ff;
   assign rsp_capture_total   = rsp_cap_cnt_ff;
   assign rsp_timeout_total   = rsp_tmo_cnt_ff;

endmodule

/* rtl/rfst_checker.sv */
// port-level checks of the frame sync tracker, bound to the top level
// depends on rfst_pkg and rx_frame_sync_tracker_macros.svh
`timescale 1ns / 1ps
`include "rx_frame_sync_tracker_macros.svh"

module rfst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_frame_synced,
   input logic                          rsp_frame_degraded,
   input logic [rfst_pkg::MODE_W-1:0]   rsp_sync_state,
   input logic                          rsp_locked_flag,
   input logic [rfst_pkg::WORD_W-1:0]   rsp_current_epoch
);
   import rfst_pkg::*;

   // lock flag tracks the locked mode exactly
   `RFST_ASSERT(a_lock_mode, clock, reset, rsp_valid |-> (rsp_locked_flag == (rsp_sync_state == MODE_LOCKED)), "lock flag disagrees with sync state")

   // a synced frame leaves the tracker locked
   `RFST_ASSERT(a_synced_locked, clock, reset, (rsp_valid && rsp_frame_synced) |-> (rsp_sync_state == MODE_LOCKED), "synced frame outside locked state")

   // a degraded frame is only reported in degraded mode
   `RFST_ASSERT(a_degraded_mode, clock, reset, (rsp_valid && rsp_frame_degraded) |-> (rsp_sync_state == MODE_DEGRADED), "degraded frame outside degraded state")

   // a frame is never both synced and degraded
   `RFST_ASSERT(a_flags_excl, clock, reset, rsp_valid |-> !(rsp_frame_synced && rsp_frame_degraded), "synced and degraded together")

   // a stalled response holds
   `RFST_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_current_epoch)), "stalled response changed")

endmodule

bind rx_frame_sync_tracker rfst_checker u_rfst_checker (.*);

/* tb/testbench.sv */
// self-checking bench for rx_frame_sync_tracker: directed table, then random sync sessions
// depends on rfst_pkg and the rx_frame_sync_tracker rtl; no files or arguments needed
`timescale 1ns / 1ps

module testbench;
   import rfst_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int unsigned MS_PER_SEC = 1000;
   localparam int N_PHASES = 8;
   localparam int PHASE_ITEMS = 124;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [WORD_W-1:0] epoch;
      logic [TICK_W-1:0] time_tick;
      logic [WORD_W-1:0] sample_index;
      logic              batch_start;
      logic [WORD_W-1:0] lost_count;
   } sync_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] frame_index_out;
      logic              frame_synced;
      logic              frame_degraded;
      logic [MODE_W-1:0] sync_state;
      logic              locked_flag;
      logic [WORD_W-1:0] current_epoch;
      logic [TICK_W-1:0] captured_tick;
      logic [WORD_W-1:0] start_index;
      logic [WORD_W-1:0] resync_total;
      logic [WORD_W-1:0] capture_total;
      logic [WORD_W-1:0] timeout_total;
   } sync_status_type;

   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [WORD_W-1:0]    csr_data;
      logic                 typed;
      sync_req_type         req;
      sync_status_type      status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CMD_W-1:0] req_command = '0;
   logic [WORD_W-1:0] req_epoch = '0;
   logic [TICK_W-1:0] req_time_tick = '0;
   logic [WORD_W-1:0] req_sample_index = '0;
   logic req_batch_start = 1'b0;
   logic [WORD_W-1:0] req_lost_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [WORD_W-1:0] rsp_frame_index_out;
   logic rsp_frame_synced;
   logic rsp_frame_degraded;
   logic [MODE_W-1:0] rsp_sync_state;
   logic rsp_locked_flag;
   logic [WORD_W-1:0] rsp_current_epoch;
   logic [TICK_W-1:0] rsp_captured_tick;
   logic [WORD_W-1:0] rsp_start_index;
   logic [WORD_W-1:0] rsp_resync_total;
   logic [WORD_W-1:0] rsp_capture_total;
   logic [WORD_W-1:0] rsp_timeout_total;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0] csr_wdata = '0;

   // tracker model state and its register copy
   logic [MODE_W-1:0] trk_mode;
   logic              trk_locked;
   logic [WORD_W-1:0] trk_epoch;
   logic [TICK_W-1:0] trk_cap_tick;
   logic [WORD_W-1:0] trk_start_idx;
   logic [WORD_W-1:0] trk_resyncs;
   logic [WORD_W-1:0] trk_captures;
   logic [WORD_W-1:0] trk_timeouts;
   logic [TICK_W-1:0] trk_armed_tick;
   logic              trk_armed_once;
   logic [CFG_W-1:0]  cfg_gap;
   logic [CFG_W-1:0]  cfg_timeout_ms;
   logic [WORD_W-1:0] cfg_timer_hz;

   sync_status_type pending_status[$];
   stim_row_type    directed_rows[$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int n_fail = 0;
   int n_accepted = 0;
   int n_effective = 0;
   int n_checked = 0;
   int n_locks = 0;
   int n_timeouts = 0;
   int n_sync_errors = 0;

   rx_frame_sync_tracker u_dut (.*);

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // random backpressure on the result side
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // poll expiry: elapsed ticks times 1000 at full width against ms times hz
   function automatic bit poll_expired(input logic [TICK_W-1:0] now);
      logic [TICK_W-1:0] elapsed;
      logic [73:0] scaled;
      logic [73:0] limit;
      elapsed = now - trk_armed_tick;
      scaled = {10'd0, elapsed} * MS_PER_SEC;
      limit = {58'd0, cfg_timeout_ms} * {42'd0, cfg_timer_hz};
      return (cfg_timer_hz == '0) || (scaled >= limit);
   endfunction

   // next status per request; acted is low for unused codes, out-of-mode captures or polls
   function automatic sync_status_type track_sync(input sync_req_type r, output bit acted);
      sync_status_type o;
      o = '0;
      acted = 1'b1;
      case (r.command)
         CMD_ARM: begin
            if (trk_armed_once) trk_resyncs = trk_resyncs + 1;
            trk_armed_once = 1'b1;
            trk_mode = MODE_ARMED;
            trk_epoch = r.epoch;
            trk_cap_tick = '0;
            trk_start_idx = '0;
            trk_locked = 1'b0;
            trk_armed_tick = r.time_tick;
         end
         CMD_CAPTURE: begin
            if (trk_mode == MODE_ARMED) begin
               trk_cap_tick = r.time_tick;
               trk_captures = trk_captures + 1;
               trk_mode = MODE_WAIT;
            end else begin
               acted = 1'b0;
            end
         end
         CMD_FRAME: begin
            o.frame_index_out = r.sample_index;
            if (trk_mode == MODE_WAIT && r.batch_start) begin
               trk_start_idx = r.sample_index;
               o.frame_index_out = '0;
               o.frame_synced = 1'b1;
               trk_locked = 1'b1;
               trk_mode = MODE_LOCKED;
               n_locks++;
            end else if (trk_mode == MODE_LOCKED) begin
               if (r.sample_index >= trk_start_idx) begin
                  o.frame_index_out = r.sample_index - trk_start_idx;
                  o.frame_synced = 1'b1;
               end else begin
                  trk_mode = MODE_ERROR;
                  trk_locked = 1'b0;
                  n_sync_errors++;
               end
            end else if (trk_mode == MODE_DEGRADED) begin
               o.frame_degraded = 1'b1;
            end
         end
         CMD_GAP: begin
            if (r.lost_count >= {16'd0, cfg_gap}) begin
               trk_mode = MODE_DEGRADED;
               trk_locked = 1'b0;
            end
         end
         CMD_OVERFLOW: begin
            trk_mode = MODE_DEGRADED;
            trk_locked = 1'b0;
         end
         CMD_POLL: begin
            if (trk_mode == MODE_ARMED || trk_mode == MODE_WAIT) begin
               if (poll_expired(r.time_tick)) begin
                  trk_timeouts = trk_timeouts + 1;
                  trk_mode = MODE_DEGRADED;
                  trk_locked = 1'b0;
                  n_timeouts++;
               end
            end else begin
               acted = 1'b0;
            end
         end
         CMD_STOP: begin
            trk_mode = MODE_IDLE;
            trk_locked = 1'b0;
         end
         default: acted = 1'b0;
      endcase
      o.sync_state = trk_mode;
      o.locked_flag = trk_locked;
      o.current_epoch = trk_epoch;
      o.captured_tick = trk_cap_tick;
      o.start_index = trk_start_idx;
      o.resync_total = trk_resyncs;
      o.capture_total = trk_captures;
      o.timeout_total = trk_timeouts;
      return o;
   endfunction

   // smallest elapsed tick count that times out under the current registers
   function automatic logic [TICK_W-1:0] timeout_ticks();
      logic [TICK_W-1:0] limit;
      limit = {48'd0, cfg_timeout_ms} * {32'd0, cfg_timer_hz};
      return (limit + MS_PER_SEC - 1) / MS_PER_SEC;
   endfunction

   function automatic sync_req_type mk_req(input logic [CMD_W-1:0] cmd,
                                           input logic [WORD_W-1:0] ep,
                                           input logic [TICK_W-1:0] tick,
                                           input logic [WORD_W-1:0] idx,
                                           input logic bstart,
                                           input logic [WORD_W-1:0] lost);
      sync_req_type r;
      r.command = cmd;
      r.epoch = ep;
      r.time_tick = tick;
      r.sample_index = idx;
      r.batch_start = bstart;
      r.lost_count = lost;
      return r;
   endfunction

   // all fields random, command as given
   function automatic sync_req_type rand_req(input logic [CMD_W-1:0] cmd);
      return mk_req(cmd, $urandom, {$urandom, $urandom}, $urandom,
                    1'($urandom_range(1)), $urandom);
   endfunction

   // poll with elapsed time around the timeout edge, below it or fully random
   function automatic sync_req_type poll_request();
      sync_req_type r;
      logic [TICK_W-1:0] thr;
      logic [TICK_W-1:0] elapsed;
      r = rand_req(CMD_POLL);
      thr = timeout_ticks();
      case ($urandom_range(5))
         0: elapsed = thr;
         1: elapsed = thr - 64'd1;
         2: elapsed = thr + 64'd1;
         3: elapsed = r.time_tick;
         default: elapsed = (thr > 64'd1) ? r.time_tick % thr : 64'd0;
      endcase
      r.time_tick = trk_armed_tick + elapsed;
      return r;
   endfunction

   // sequence gap with a lost count around the degrade threshold, zero or random
   function automatic sync_req_type gap_request();
      sync_req_type r;
      r = rand_req(CMD_GAP);
      case ($urandom_range(4))
         0: r.lost_count = {16'd0, cfg_gap} - 32'd1;
         1: r.lost_count = {16'd0, cfg_gap};
         2: r.lost_count = {16'd0, cfg_gap} + 32'd1;
         3: r.lost_count = 32'd0;
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_request(input sync_req_type r);
      stim_row_type row;
      row = '0;
      row.req = r;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input sync_req_type r, input sync_status_type s);
      stim_row_type row;
      row = '0;
      row.req = r;
      row.typed = 1'b1;
      row.status = s;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [WORD_W-1:0] data);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_data = data;
      directed_rows.push_back(row);
   endfunction

   // present one request, hold it until taken, then record what it should return
   task automatic send_request(input sync_req_type r, input bit typed = 1'b0,
                               input sync_status_type typed_status = '0);
      sync_status_type predicted;
      bit acted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.command;
      req_epoch <= r.epoch;
      req_time_tick <= r.time_tick;
      req_sample_index <= r.sample_index;
      req_batch_start <= r.batch_start;
      req_lost_count <= r.lost_count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = track_sync(r, acted);
      pending_status.push_back(typed ? typed_status : predicted);
      n_accepted++;
      if (acted) n_effective++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_LARGE_GAP: cfg_gap = data[CFG_W-1:0];
         REG_TIMEOUT:   cfg_timeout_ms = data[CFG_W-1:0];
         REG_TIMER_HZ:  cfg_timer_hz = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // arm, capture, batch start, then a run of frames with gaps and faults mixed in
   task automatic run_sync_session();
      sync_req_type r;
      logic [WORD_W-1:0] start_idx;
      logic [WORD_W-1:0] next_idx;
      int pick;
      send_request(rand_req(CMD_ARM));
      if ($urandom_range(99) < 25) send_request(poll_request());
      if ($urandom_range(99) < 10) begin
         r = rand_req(CMD_FRAME);
         r.batch_start = 1'b1;
         send_request(r);
      end
      if ($urandom_range(99) < 92) send_request(rand_req(CMD_CAPTURE));
      if ($urandom_range(99) < 25) send_request(poll_request());
      if ($urandom_range(99) < 15) begin
         r = rand_req(CMD_FRAME);
         r.batch_start = 1'b0;
         send_request(r);
      end
      // start index near the top now and then so indexes wrap
      if ($urandom_range(9) == 0) start_idx = 32'hFFFF_FFFF - $urandom_range(20);
      else start_idx = $urandom;
      r = rand_req(CMD_FRAME);
      r.sample_index = start_idx;
      r.batch_start = 1'b1;
      send_request(r);
      next_idx = start_idx;
      repeat ($urandom_range(2, 14)) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            next_idx = next_idx + $urandom_range(1, 4);
            r = rand_req(CMD_FRAME);
            r.sample_index = next_idx;
         end else if (pick < 76) begin
            r = rand_req(CMD_FRAME);
            r.sample_index = start_idx - $urandom_range(1, 3);
         end else if (pick < 86) begin
            r = gap_request();
         end else if (pick < 90) begin
            r = rand_req(CMD_OVERFLOW);
         end else if (pick < 95) begin
            r = poll_request();
         end else begin
            r = rand_req(CMD_FRAME);
         end
         send_request(r);
      end
      if ($urandom_range(99) < 30) send_request(rand_req(CMD_STOP));
   endtask

   // result checker
   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      sync_status_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("result arrived with no request outstanding");
            n_fail++;
         end else begin
            exp_s = pending_status.pop_front();
            n_checked++;
            check_field("frame_index_out", exp_s.frame_index_out, rsp_frame_index_out);
            check_field("frame_synced", exp_s.frame_synced, rsp_frame_synced);
            check_field("frame_degraded", exp_s.frame_degraded, rsp_frame_degraded);
            check_field("sync_state", exp_s.sync_state, rsp_sync_state);
            check_field("locked_flag", exp_s.locked_flag, rsp_locked_flag);
            check_field("current_epoch", exp_s.current_epoch, rsp_current_epoch);
            check_field("captured_tick", exp_s.captured_tick, rsp_captured_tick);
            check_field("start_index", exp_s.start_index, rsp_start_index);
            check_field("resync_total", exp_s.resync_total, rsp_resync_total);
            check_field("capture_total", exp_s.capture_total, rsp_capture_total);
            check_field("timeout_total", exp_s.timeout_total, rsp_timeout_total);
         end
      end
   end

   // main sequence
   initial begin
      sync_status_type s;
      int phase_base;
      logic [WORD_W-1:0] gap_w;
      logic [WORD_W-1:0] tmo_w;
      logic [WORD_W-1:0] hz_w;

      trk_mode = MODE_IDLE;
      trk_locked = 1'b0;
      trk_epoch = '0;
      trk_cap_tick = '0;
      trk_start_idx = '0;
      trk_resyncs = '0;
      trk_captures = '0;
      trk_timeouts = '0;
      trk_armed_tick = '0;
      trk_armed_once = 1'b0;
      cfg_gap = LARGE_GAP_RST;
      cfg_timeout_ms = TIMEOUT_RST;
      cfg_timer_hz = TIMER_HZ_RST;

      // directed table, reset registers first
      s = '0;
      add_checked(mk_req(CMD_POLL, '1, '1, '1, 1'b1, '1), s);
      s.frame_index_out = '1;
      add_checked(mk_req(CMD_FRAME, '1, '1, '1, 1'b1, '1), s);
      s = '0;
      add_checked(mk_req(CMD_CAPTURE, '1, '1, '1, 1'b1, '1), s);
      add_checked(mk_req(CMD_UNUSED, '1, '1, '1, 1'b1, '1), s);
      s.sync_state = MODE_ARMED;
      s.current_epoch = '1;
      add_checked(mk_req(CMD_ARM, '1, 64'hFFFF_FFFF_FFFF_FF00, '0, 1'b0, '0), s);
      // one tick short of the timeout, then exactly on it, across the 64-bit wrap
      add_request(mk_req(CMD_POLL, '0, 64'hFFFF_FFFF_FFFF_FF00 + 64'd999_999, '0,
                         1'b0, '0));
      add_request(mk_req(CMD_FRAME, '0, '0, 32'd5, 1'b1, '0));
      add_request(mk_req(CMD_CAPTURE, '0, '1, '0, 1'b0, '0));
      add_request(mk_req(CMD_POLL, '0, 64'hFFFF_FFFF_FFFF_FF00 + 64'd1_000_000, '0,
                         1'b0, '0));
      add_request(mk_req(CMD_FRAME, '0, '0, 32'd9, 1'b0, '0));
      // re-arm, lock at the top index, then fall below it
      add_request(mk_req(CMD_ARM, '0, '0, '0, 1'b0, '0));
      add_request(mk_req(CMD_CAPTURE, '0, '0, '0, 1'b0, '0));
      add_request(mk_req(CMD_FRAME, '0, '0, '1, 1'b1, '0));
      add_request(mk_req(CMD_FRAME, '0, '0, '1, 1'b0, '0));
      add_request(mk_req(CMD_FRAME, '0, '0, 32'hFFFF_FFFE, 1'b0, '0));
      add_request(mk_req(CMD_GAP, '0, '0, '0, 1'b0, 32'd7));
      add_request(mk_req(CMD_GAP, '0, '0, '0, 1'b0, 32'd8));
      add_request(mk_req(CMD_STOP, '0, '0, '0, 1'b0, '0));
      // zero registers: any gap degrades, zero frequency times out at once
      add_csr(REG_LARGE_GAP, '0);
      add_csr(REG_TIMEOUT, '0);
      add_csr(REG_TIMER_HZ, '0);
      add_request(mk_req(CMD_ARM, 32'd1, 64'd5, '0, 1'b0, '0));
      add_request(mk_req(CMD_GAP, '0, '0, '0, 1'b0, '0));
      add_request(mk_req(CMD_ARM, 32'd2, 64'd5, '0, 1'b0, '0));
      add_request(mk_req(CMD_POLL, '0, 64'd5, '0, 1'b0, '0));
      // top registers: wrapped elapsed time overflows the product
      add_csr(REG_LARGE_GAP, '1);
      add_csr(REG_TIMEOUT, '1);
      add_csr(REG_TIMER_HZ, '1);
      add_request(mk_req(CMD_ARM, '0, 64'd1, '0, 1'b0, '0));
      add_request(mk_req(CMD_POLL, '0, '0, '0, 1'b0, '0));
      add_request(mk_req(CMD_OVERFLOW, '0, '0, '0, 1'b0, '0));
      add_request(mk_req(CMD_GAP, '0, '0, '0, 1'b0, '1));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_data);
         end else begin
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].status);
         end
      end

      // random phases, each with one of four idle patterns and its own register setting
      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         case (p)
            0: begin gap_w = 32'd8;   tmo_w = 32'd1000;  hz_w = 32'd1_000_000; end
            1: begin gap_w = 32'd0;   tmo_w = 32'd0;     hz_w = 32'd0;         end
            2: begin gap_w = 32'hFFFF; tmo_w = 32'hFFFF; hz_w = 32'hFFFF_FFFF; end
            3: begin gap_w = 32'd1;   tmo_w = 32'd1;     hz_w = 32'd1;         end
            4: begin gap_w = 32'd3;   tmo_w = 32'd50;    hz_w = 32'd32768;     end
            default: begin
               // upper bits of the 16-bit registers are random too
               gap_w = {16'($urandom_range(16'hFFFF)), 16'($urandom_range(20))};
               tmo_w = $urandom;
               hz_w = $urandom;
            end
         endcase
         write_csr(REG_LARGE_GAP, gap_w);
         write_csr(REG_TIMEOUT, tmo_w);
         write_csr(REG_TIMER_HZ, hz_w);
         phase_base = n_accepted;
         while (n_accepted - phase_base < PHASE_ITEMS) begin
            if ($urandom_range(99) < 80) begin
               run_sync_session();
            end else begin
               repeat ($urandom_range(1, 3))
                  send_request(rand_req(CMD_W'($urandom_range(7))));
            end
         end
      end

      drain();
      repeat (16) @(posedge clock);
      $display("run: %0d requests accepted (%0d acted on), %0d results checked over %0d phases",
               n_accepted, n_effective, n_checked, N_PHASES);
      $display("run: %0d locks, %0d timeouts, %0d index faults predicted",
               n_locks, n_timeouts, n_sync_errors);
      if (n_fail == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("timeout: run did not complete");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rfst_pkg.sv
rtl/rfst_ctrl.sv
rtl/rfst_dpath.sv
rtl/rx_frame_sync_tracker.sv
rtl/rfst_checker.sv
tb/testbench.sv
